// ----- sv/iup_pkg.sv -----
// Package for the interpolating upsampler: sizes, register indexes,
// microcode word layout and the microprogram ROM.
// No dependencies.
package iup_pkg;

   localparam int CHANNELS = 2;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HIST_DEPTH = 3;

   localparam logic [10:0] STEP_MIN   = 11'd64;
   localparam logic [10:0] STEP_MAX   = 11'd1024;
   localparam logic [10:0] STEP_RESET = 11'd1024;
   localparam logic [10:0] PHASE_ONE  = 11'd1024;

   // configuration register indexes
   localparam logic [0:0] CSR_PHASE_STEP  = 1'b0;
   localparam logic [0:0] CSR_INTERP_MODE = 1'b1;

   localparam logic MODE_LINEAR = 1'b0;
   localparam logic MODE_CUBIC  = 1'b1;

   // microprogram addresses
   localparam int UADDR_W = 4;
   localparam logic [UADDR_W-1:0] UA_WAIT     = 4'd0;
   localparam logic [UADDR_W-1:0] UA_COEF     = 4'd1;
   localparam logic [UADDR_W-1:0] UA_CUB_S2   = 4'd2;
   localparam logic [UADDR_W-1:0] UA_CUB_T    = 4'd3;
   localparam logic [UADDR_W-1:0] UA_CUB_C3   = 4'd4;
   localparam logic [UADDR_W-1:0] UA_CUB_C2   = 4'd5;
   localparam logic [UADDR_W-1:0] UA_CUB_C1   = 4'd6;
   localparam logic [UADDR_W-1:0] UA_CUB_EMIT = 4'd7;
   localparam logic [UADDR_W-1:0] UA_LIN_MUL  = 4'd8;
   localparam logic [UADDR_W-1:0] UA_LIN_EMIT = 4'd9;
   localparam logic [UADDR_W-1:0] UA_COMMIT   = 4'd10;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_LINEAR,
      COND_MORE
   } cond_type;

   typedef enum logic [2:0] {
      A_S,
      A_C3,
      A_T,
      A_C2,
      A_C1,
      A_D
   } asel_type;

   typedef enum logic {
      B_S,
      B_S2
   } bsel_type;

   typedef enum logic [1:0] {
      P_NONE,
      P_S2,
      P_T
   } pdst_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_V1,
      ACC_ADD,
      ACC_H2_ADD
   } acc_type;

   typedef struct packed {
      cond_type            cond;
      logic [UADDR_W-1:0]  jmp_t;
      logic [UADDR_W-1:0]  jmp_f;
      asel_type            asel;
      bsel_type            bsel;
      pdst_type            pdst;
      acc_type             accop;
      logic                coef;
      logic                emit;
      logic                commit;
   } ucode_word_type;

   function automatic ucode_word_type uw(
      input cond_type           cond,
      input logic [UADDR_W-1:0] jmp_t,
      input logic [UADDR_W-1:0] jmp_f,
      input asel_type           asel,
      input bsel_type           bsel,
      input pdst_type           pdst,
      input acc_type            accop,
      input logic               coef,
      input logic               emit,
      input logic               commit
   );
      ucode_word_type w;
      w.cond   = cond;
      w.jmp_t  = jmp_t;
      w.jmp_f  = jmp_f;
      w.asel   = asel;
      w.bsel   = bsel;
      w.pdst   = pdst;
      w.accop  = accop;
      w.coef   = coef;
      w.emit   = emit;
      w.commit = commit;
      return w;
   endfunction

   function automatic ucode_word_type ucode_rom(input logic [UADDR_W-1:0] addr);
      ucode_word_type w;
      unique case (addr)
         UA_WAIT:     w = uw(COND_ACCEPT, UA_COEF, UA_WAIT, A_S, B_S, P_NONE, ACC_HOLD,
                             1'b0, 1'b0, 1'b0);
         UA_COEF:     w = uw(COND_LINEAR, UA_LIN_MUL, UA_CUB_S2, A_S, B_S, P_NONE,
                             ACC_HOLD, 1'b1, 1'b0, 1'b0);
         UA_CUB_S2:   w = uw(COND_ALWAYS, UA_CUB_T, UA_CUB_T, A_S, B_S, P_S2, ACC_V1,
                             1'b0, 1'b0, 1'b0);
         UA_CUB_T:    w = uw(COND_ALWAYS, UA_CUB_C3, UA_CUB_C3, A_C3, B_S, P_T, ACC_HOLD,
                             1'b0, 1'b0, 1'b0);
         UA_CUB_C3:   w = uw(COND_ALWAYS, UA_CUB_C2, UA_CUB_C2, A_T, B_S2, P_NONE, ACC_ADD,
                             1'b0, 1'b0, 1'b0);
         UA_CUB_C2:   w = uw(COND_ALWAYS, UA_CUB_C1, UA_CUB_C1, A_C2, B_S2, P_NONE,
                             ACC_ADD, 1'b0, 1'b0, 1'b0);
         UA_CUB_C1:   w = uw(COND_ALWAYS, UA_CUB_EMIT, UA_CUB_EMIT, A_C1, B_S, P_NONE,
                             ACC_ADD, 1'b0, 1'b0, 1'b0);
         UA_CUB_EMIT: w = uw(COND_MORE, UA_CUB_S2, UA_COMMIT, A_S, B_S, P_NONE, ACC_HOLD,
                             1'b0, 1'b1, 1'b0);
         UA_LIN_MUL:  w = uw(COND_ALWAYS, UA_LIN_EMIT, UA_LIN_EMIT, A_D, B_S, P_NONE,
                             ACC_H2_ADD, 1'b0, 1'b0, 1'b0);
         UA_LIN_EMIT: w = uw(COND_MORE, UA_LIN_MUL, UA_COMMIT, A_S, B_S, P_NONE, ACC_HOLD,
                             1'b0, 1'b1, 1'b0);
         UA_COMMIT:   w = uw(COND_ALWAYS, UA_WAIT, UA_WAIT, A_S, B_S, P_NONE, ACC_HOLD,
                             1'b0, 1'b0, 1'b1);
         default:     w = uw(COND_ALWAYS, UA_WAIT, UA_WAIT, A_S, B_S, P_NONE, ACC_HOLD,
                             1'b0, 1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

// ----- sv/interpolating_upsampler_top.sv -----
// Flow: after an accepted word the sequencer runs a coefficient step, then per result the steps
// S2, T, C3, C2, C1 and emit (cubic) or multiply and emit (linear), then commit; n = 1..16
// results per input word, all through the shared multiplier; req_ready is high only in wait.
// Output stalls add cycles at the emit steps only.
// Synchronous active-high reset clears history, phases, config (step 1024, cubic), sequencer.
// Interpolating upsampler: microcoded sequencer over one multiply-accumulate datapath.
// Depends on iup_pkg.
module interpolating_upsampler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_channel,
   input  logic signed [15:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_channel,
   output logic signed [15:0] rsp_out_sample,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam int CHW = iup_pkg::CH_IDX_W;

   logic [10:0] cfg_step_ff;
   logic        cfg_mode_ff;

   logic signed [15:0] hist_ff [iup_pkg::CHANNELS][iup_pkg::HIST_DEPTH];
   logic [10:0]        phase_ff [iup_pkg::CHANNELS];

   logic [iup_pkg::UADDR_W-1:0] upc_ff, upc_in;

   logic [CHW-1:0]     ch_ff;
   logic signed [15:0] v0_ff, v1_ff, v2_ff, v3_ff;
   logic [10:0]        step_ff;
   logic [10:0]        p_ff;
   logic signed [17:0] c3_ff;
   logic signed [18:0] c2_ff;
   logic signed [16:0] c1_ff;
   logic signed [16:0] d_ff;
   logic [9:0]         s2_ff;
   logic signed [17:0] t_ff;
   logic signed [20:0] acc_ff;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_ch_ff;
   logic signed [15:0] rsp_sample_ff;
   logic               rsp_last_ff;

   iup_pkg::ucode_word_type cw;
   logic        chan_ok, accept, out_free, go, more, cond_true;
   logic [11:0] p_sum;
   logic [10:0] step_sat;
   logic signed [19:0] a_op;
   logic signed [11:0] b_op;
   logic signed [31:0] prod;
   logic signed [21:0] prod_q;
   logic signed [19:0] w0, w1, w2, w3, c3_w, c2_w, c1_w, d_w;
   logic signed [15:0] sat_w;
   logic [10:0] phase_in;

   assign cw        = iup_pkg::ucode_rom(upc_ff);
   assign chan_ok   = ({1'b0, req_channel} < 4'(iup_pkg::CHANNELS));
   assign req_ready = (upc_ff == iup_pkg::UA_WAIT);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign go        = !cw.emit || out_free;
   assign p_sum     = {1'b0, p_ff} + {1'b0, step_ff};
   assign more      = (p_sum < {1'b0, iup_pkg::PHASE_ONE});

   always_comb begin
      if (cfg_step_ff < iup_pkg::STEP_MIN) begin
         step_sat = iup_pkg::STEP_MIN;
      end else if (cfg_step_ff > iup_pkg::STEP_MAX) begin
         step_sat = iup_pkg::STEP_MAX;
      end else begin
         step_sat = cfg_step_ff;
      end
   end

   always_comb begin
      unique case (cw.cond)
         iup_pkg::COND_ALWAYS: cond_true = 1'b1;
         iup_pkg::COND_ACCEPT: cond_true = req_valid && chan_ok;
         iup_pkg::COND_LINEAR: cond_true = (cfg_mode_ff == iup_pkg::MODE_LINEAR);
         iup_pkg::COND_MORE:   cond_true = more;
         default:              cond_true = 1'b0;
      endcase
      if (go) begin
         upc_in = cond_true ? cw.jmp_t : cw.jmp_f;
      end else begin
         upc_in = upc_ff;
      end
   end

   // shared multiplier; phase is below one whenever its product is used
   always_comb begin
      unique case (cw.asel)
         iup_pkg::A_S:  a_op = $signed({9'd0, p_ff});
         iup_pkg::A_C3: a_op = 20'(c3_ff);
         iup_pkg::A_T:  a_op = 20'(t_ff);
         iup_pkg::A_C2: a_op = 20'(c2_ff);
         iup_pkg::A_C1: a_op = 20'(c1_ff);
         iup_pkg::A_D:  a_op = 20'(d_ff);
         default:       a_op = '0;
      endcase
      unique case (cw.bsel)
         iup_pkg::B_S:  b_op = $signed({1'b0, p_ff});
         iup_pkg::B_S2: b_op = $signed({2'b00, s2_ff});
         default:       b_op = '0;
      endcase
   end

   assign prod   = a_op * b_op;
   assign prod_q = $signed(prod[31:10]);   // floor shift by 10

   // Catmull-Rom coefficients, computed once per input word
   always_comb begin
      w0   = 20'(v0_ff);
      w1   = 20'(v1_ff);
      w2   = 20'(v2_ff);
      w3   = 20'(v3_ff);
      c3_w = (w1 - w2) + ((w3 + w1 - w2 - w0) >>> 1);
      c2_w = w0 + ((w2 - w1) <<< 1) - ((w1 + w3) >>> 1);
      c1_w = (w2 - w0) >>> 1;
      d_w  = w3 - w2;
   end

   always_comb begin
      if (acc_ff > 21'sd32767) begin
         sat_w = 16'sh7FFF;
      end else if (acc_ff < -21'sd32768) begin
         sat_w = -16'sh8000;
      end else begin
         sat_w = acc_ff[15:0];
      end
   end

   assign phase_in = p_ff[10] ? {1'b0, p_ff[9:0]} : p_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= iup_pkg::UA_WAIT;
         rsp_valid_ff <= 1'b0;
         cfg_step_ff  <= iup_pkg::STEP_RESET;
         cfg_mode_ff  <= iup_pkg::MODE_CUBIC;
         for (int i = 0; i < iup_pkg::CHANNELS; i++) begin
            phase_ff[i] <= '0;
            for (int j = 0; j < iup_pkg::HIST_DEPTH; j++) begin
               hist_ff[i][j] <= '0;
            end
         end
      end else begin
         upc_ff <= upc_in;
         if (csr_valid) begin
            unique case (csr_index)
               iup_pkg::CSR_PHASE_STEP:  cfg_step_ff <= csr_data;
               iup_pkg::CSR_INTERP_MODE: cfg_mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cw.emit && go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cw.commit) begin
            hist_ff[ch_ff][0] <= v1_ff;
            hist_ff[ch_ff][1] <= v2_ff;
            hist_ff[ch_ff][2] <= v3_ff;
            phase_ff[ch_ff]   <= phase_in;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && chan_ok) begin
         ch_ff   <= req_channel[CHW-1:0];
         v0_ff   <= hist_ff[req_channel[CHW-1:0]][0];
         v1_ff   <= hist_ff[req_channel[CHW-1:0]][1];
         v2_ff   <= hist_ff[req_channel[CHW-1:0]][2];
         v3_ff   <= req_sample;
         p_ff    <= phase_ff[req_channel[CHW-1:0]];
         step_ff <= step_sat;
      end
      if (cw.coef) begin
         c3_ff <= c3_w[17:0];
         c2_ff <= c2_w[18:0];
         c1_ff <= c1_w[16:0];
         d_ff  <= d_w[16:0];
      end
      case (cw.pdst)
         iup_pkg::P_S2: s2_ff <= prod_q[9:0];
         iup_pkg::P_T:  t_ff  <= prod_q[17:0];
         default: ;
      endcase
      case (cw.accop)
         iup_pkg::ACC_V1:     acc_ff <= 21'(v1_ff);
         iup_pkg::ACC_ADD:    acc_ff <= acc_ff + prod_q[20:0];
         iup_pkg::ACC_H2_ADD: acc_ff <= 21'(v2_ff) + prod_q[20:0];
         default: ;
      endcase
      if (cw.emit && go) begin
         rsp_ch_ff     <= 3'(ch_ff);
         rsp_sample_ff <= sat_w;
         rsp_last_ff   <= !more;
         p_ff          <= p_sum[10:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_emit_in_phase: assert property (@(posedge clock) disable iff (reset)
      (cw.emit && go) |-> (p_ff < iup_pkg::PHASE_ONE))
      else $error("result emitted with phase at or above one");

   a_commit_after_wrap: assert property (@(posedge clock) disable iff (reset)
      cw.commit |-> (p_ff >= iup_pkg::PHASE_ONE))
      else $error("history committed before phase wrapped");

   a_last_then_commit: assert property (@(posedge clock) disable iff (reset)
      (cw.emit && go && !more) |=> (upc_ff == iup_pkg::UA_COMMIT))
      else $error("last word of run not followed by commit");

   a_upc_range: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= iup_pkg::UA_COMMIT)
      else $error("step counter outside program");

endmodule
